// ===== rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// shared types and constants for the vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;
	localparam int CW       = 16;
	localparam int FB       = 12;
	localparam int LANES    = 4;
	localparam int DIMS_W   = 3;
	localparam int EPS_W    = 24;
	localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(168);
	localparam int SQ_W     = 2*CW - 1;
	localparam int S_W      = SQ_W + 2;
	localparam int ACC_W    = S_W + 2*FB + 8;
	localparam int ITERS    = FB + 1;
	localparam int FIFO_D   = 4;
	localparam int FIFO_AW  = $clog2(FIFO_D);

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [LANES-1:0][CW-1:0]   v;
		logic [LANES-1:0][SQ_W-1:0] sq;
		logic [S_W-1:0]             s;
		logic                       bypass;
	} item_t;

	typedef struct packed {
		logic rdy;
		logic nonempty;
	} fifo_stat_t;
endpackage

// ===== rtl/vn_if.sv =====
// ----------------------------------------------------------------------------
// vn_in_if / vn_out_if
// valid/ready channels for vectors in and normalized vectors out
// ----------------------------------------------------------------------------
interface vn_in_if;
	import vn_pkg::*;
	logic              valid;
	logic              ready;
	logic [DIMS_W-1:0] dims;
	logic [CW-1:0]     x_in;
	logic [CW-1:0]     y_in;
	logic [CW-1:0]     z_in;
	logic [CW-1:0]     w_in;
	modport source (output valid, dims, x_in, y_in, z_in, w_in, input ready);
	modport sink   (input valid, dims, x_in, y_in, z_in, w_in, output ready);
endinterface

interface vn_out_if;
	import vn_pkg::*;
	logic          valid;
	logic          ready;
	logic [CW-1:0] x_out;
	logic [CW-1:0] y_out;
	logic [CW-1:0] z_out;
	logic [CW-1:0] w_out;
	logic          bypassed;
	modport source (output valid, x_out, y_out, z_out, w_out, bypassed, input ready);
	modport sink   (input valid, x_out, y_out, z_out, w_out, bypassed, output ready);
endinterface

// ===== rtl/vn_front.sv =====
// ----------------------------------------------------------------------------
// vn_front
// accepts vectors, squares components, sums squared length and decides bypass
// ----------------------------------------------------------------------------
module vn_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [vn_pkg::EPS_W-1:0] eps,
	vn_in_if.sink                    vec_in,
	input  logic                     q_rdy,
	output logic                     push,
	output vn_pkg::item_t            push_item
);
	import vn_pkg::*;

	logic                       valid_s1, valid_s2;
	logic [LANES-1:0][CW-1:0]   v_s1;
	logic [LANES-1:0][SQ_W-1:0] sq_s1;
	item_t                      item_s2;
	logic                       en;
	logic [LANES-1:0][CW-1:0]   v_c;
	logic [LANES-1:0][SQ_W-1:0] sq_c;
	logic [LANES-1:0]           use_c;
	logic [S_W-1:0]             s_c, diff_c, one_c, eps_c;
	logic [CW-1:0]              mag;

	assign en           = !valid_s2 || q_rdy;
	assign vec_in.ready = en;
	assign push         = valid_s2 && q_rdy;
	assign push_item    = item_s2;

	always_comb begin
		mag = '0;
		use_c[0] = 1'b1;
		use_c[1] = 1'b1;
		use_c[2] = (vec_in.dims >= DIMS_W'(3));
		use_c[3] = (vec_in.dims >= DIMS_W'(4));
		v_c[0] = vec_in.x_in;
		v_c[1] = vec_in.y_in;
		v_c[2] = use_c[2] ? vec_in.z_in : '0;
		v_c[3] = use_c[3] ? vec_in.w_in : '0;
		for (int i = 0; i < LANES; i++) begin
			mag = v_c[i][CW-1] ? (~v_c[i] + CW'(1)) : v_c[i];
			sq_c[i] = SQ_W'({{CW{1'b0}}, mag} * {{CW{1'b0}}, mag});
		end
	end

	always_comb begin
		s_c = '0;
		for (int i = 0; i < LANES; i++) begin
			s_c = s_c + S_W'(sq_s1[i]);
		end
		one_c  = S_W'(1) << (2*FB);
		diff_c = (s_c >= one_c) ? (s_c - one_c) : (one_c - s_c);
		eps_c  = S_W'(eps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1           <= v_c;
			sq_s1          <= sq_c;
			item_s2.v      <= v_s1;
			item_s2.sq     <= sq_s1;
			item_s2.s      <= s_c;
			item_s2.bypass <= (s_c < eps_c) || (diff_c < eps_c);
		end
	end
endmodule

// ===== rtl/vn_fifo.sv =====
// ----------------------------------------------------------------------------
// vn_fifo
// short queue between the classifying front and the iterating back end
// ----------------------------------------------------------------------------
module vn_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vn_pkg::item_t      push_item,
	input  logic               pop,
	output vn_pkg::item_t      head,
	output vn_pkg::fifo_stat_t stat
);
	import vn_pkg::*;

	item_t              mem [FIFO_D];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign stat.rdy      = (cnt_q < (FIFO_AW+1)'(FIFO_D));
	assign stat.nonempty = (cnt_q != '0);
	assign head          = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end
endmodule

// ===== rtl/vn_back.sv =====
// ----------------------------------------------------------------------------
// vn_back
// bit-per-stage reciprocal square root scaling with incremental products
// ----------------------------------------------------------------------------
module vn_back (
	input  logic               clk,
	input  logic               arst_n,
	input  vn_pkg::item_t      head,
	input  vn_pkg::fifo_stat_t stat,
	output logic               pop,
	vn_out_if.source           vec_out
);
	import vn_pkg::*;

	logic                      en;
	logic                      val_s [ITERS+1];
	item_t                     itm_s [ITERS+1];
	logic [LANES-1:0][FB:0]    n_s   [ITERS+1];
	acc_t                      p_s   [ITERS+1][LANES];
	acc_t                      q_s   [ITERS+1][LANES];
	logic                      out_valid_q;
	logic [LANES-1:0][CW-1:0]  res_c, res_q;
	logic                      byp_q;

	assign en  = !out_valid_q || vec_out.ready;
	assign pop = en && stat.nonempty;

	// first stage loads the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s[0] <= 1'b0;
		end else if (en) begin
			val_s[0] <= stat.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s[0] <= head;
			n_s[0]   <= '0;
			for (int i = 0; i < LANES; i++) begin
				p_s[0][i] <= acc_t'(head.s);
				q_s[0][i] <= -acc_t'(head.s);
			end
		end
	end

	for (genvar k = 0; k < ITERS; k++) begin : g_stage
		localparam int B = FB - k;
		acc_t                   pc [LANES];
		acc_t                   qc [LANES];
		logic [LANES-1:0]       take;
		acc_t                   sx;

		always_comb begin
			sx = acc_t'(itm_s[k].s);
			for (int i = 0; i < LANES; i++) begin
				pc[i]   = p_s[k][i] + (q_s[k][i] <<< (B+2)) + (sx <<< (2*B+2));
				qc[i]   = q_s[k][i] + (sx <<< (B+1));
				take[i] = ((B == FB) || !n_s[k][i][FB]) &&
				          (pc[i] <= (acc_t'(itm_s[k].sq[i]) <<< (2*FB+2)));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k+1] <= 1'b0;
			end else if (en) begin
				val_s[k+1] <= val_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[k+1] <= itm_s[k];
				for (int i = 0; i < LANES; i++) begin
					n_s[k+1][i] <= take[i] ? (n_s[k][i] | ((FB+1)'(1) << B)) : n_s[k][i];
					p_s[k+1][i] <= take[i] ? pc[i] : p_s[k][i];
					q_s[k+1][i] <= take[i] ? qc[i] : q_s[k][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (itm_s[ITERS].bypass) begin
				res_c[i] = itm_s[ITERS].v[i];
			end else if (itm_s[ITERS].s == '0) begin
				res_c[i] = '0;
			end else if (itm_s[ITERS].v[i][CW-1]) begin
				res_c[i] = CW'(-{{(CW-FB-1){1'b0}}, n_s[ITERS][i]});
			end else begin
				res_c[i] = CW'(n_s[ITERS][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= val_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
			byp_q <= itm_s[ITERS].bypass;
		end
	end

	assign vec_out.valid    = out_valid_q;
	assign vec_out.x_out    = res_q[0];
	assign vec_out.y_out    = res_q[1];
	assign vec_out.z_out    = res_q[2];
	assign vec_out.w_out    = res_q[3];
	assign vec_out.bypassed = byp_q;
endmodule

// ===== rtl/vector_normalize.sv =====
// ----------------------------------------------------------------------------
// vector_normalize
// normalizes 2- to 4-component Q4.12 vectors, passing near-zero and unit ones
// stages in order: front squares and sum, queue, load, 13 square-root bit stages, output register
// throughput: one vector per cycle while the output is not stalled, set by the one-bit-per-stage root pipeline
// reset clears all valid flags and the queue, epsilon returns to 168
// ----------------------------------------------------------------------------
module vector_normalize (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [vn_pkg::EPS_W-1:0] cfg_wdata,
	vn_in_if.sink                    vec_in,
	vn_out_if.source                 vec_out
);
	import vn_pkg::*;

	logic [EPS_W-1:0] eps_q;
	logic             push, pop;
	item_t            push_item, head;
	fifo_stat_t       stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	vn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.eps       (eps_q),
		.vec_in    (vec_in),
		.q_rdy     (stat.rdy),
		.push      (push),
		.push_item (push_item)
	);

	vn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	vn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.pop     (pop),
		.vec_out (vec_out)
	);
endmodule

// ===== rtl/vn_checker.sv =====
// ----------------------------------------------------------------------------
// vn_checker
// port-level checks on the normalized output stream
// ----------------------------------------------------------------------------
module vn_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  o_valid,
	input logic                  o_ready,
	input logic [vn_pkg::CW-1:0] x_out,
	input logic [vn_pkg::CW-1:0] y_out,
	input logic                  bypassed
);
	import vn_pkg::*;

	localparam logic signed [CW-1:0] ONE_P = CW'(1) << FB;
	localparam logic signed [CW-1:0] ONE_N = -(CW'(1) << FB);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(x_out) && $stable(bypassed))
		else $error("output transaction changed while stalled");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !bypassed |-> $signed(x_out) <= ONE_P && $signed(x_out) >= ONE_N)
		else $error("normalized x above unit magnitude");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !bypassed |-> $signed(y_out) <= ONE_P && $signed(y_out) >= ONE_N)
		else $error("normalized y above unit magnitude");

	a_rst: assert property (@(posedge clk) !arst_n |-> !o_valid)
		else $error("output valid during reset");
endmodule

bind vector_normalize vn_checker u_vn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.o_valid  (vec_out.valid),
	.o_ready  (vec_out.ready),
	.x_out    (vec_out.x_out),
	.y_out    (vec_out.y_out),
	.bypassed (vec_out.bypassed)
);
